/* src/detection_record_decoder_assert.svh */
`ifndef DETECTION_RECORD_DECODER_ASSERT_SVH
`define DETECTION_RECORD_DECODER_ASSERT_SVH

// Checks that a condition holds in the same cycle whenever the antecedent holds.
`define DRD_ASSERT_IMPL(name, clk_s, rstn_s, ante, cons, msg) \
  name: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |-> (cons)) \
    else $error(msg);

// Checks that a condition holds in the cycle after the antecedent holds.
`define DRD_ASSERT_NEXT(name, clk_s, rstn_s, ante, cons, msg) \
  name: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* src/drd_pkg.sv */
package drd_pkg;

  // Record layout and field widths.
  localparam int BOX_VALUES      = 5;
  localparam int DEF_MAX_CLASSES = 128;
  localparam int RAW_W           = 32;
  localparam int COORD_W         = 16;
  localparam int CLASS_INDEX_W   = 7;
  localparam int SCORE_W         = 32;
  localparam int CLASS_COUNT_W   = 8;
  localparam int PROD_W          = 2 * RAW_W;
  localparam int OUT_DATA_W      = 104;
  localparam int IN_DATA_W       = 32;

  // Configuration port.
  localparam int CFG_INDEX_W = 1;
  localparam int CFG_DATA_W  = 32;
  localparam logic [CFG_INDEX_W-1:0] REG_SCORE_THRESHOLD = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] REG_CLASS_COUNT     = 1'b1;
  localparam logic signed [RAW_W-1:0]   THRESHOLD_RESET   = 32'sd32768;
  localparam logic [CLASS_COUNT_W-1:0]  CLASS_COUNT_RESET = 8'd80;

  // Positions of the box values at the head of a record.
  localparam int POS_CENTER_X = 0;
  localparam int POS_CENTER_Y = 1;
  localparam int POS_SIZE_X   = 2;
  localparam int POS_SIZE_Y   = 3;

  // A finished record that passed the threshold test.
  typedef struct packed {
    logic [RAW_W-1:0]         center_x;
    logic [RAW_W-1:0]         center_y;
    logic [RAW_W-1:0]         size_x;
    logic [RAW_W-1:0]         size_y;
    logic [RAW_W-1:0]         objectness;
    logic [RAW_W-1:0]         best_score;
    logic [CLASS_INDEX_W-1:0] best_class;
  } rec_t;

  // Q16.16 to integer, truncated toward zero.
  function automatic logic signed [COORD_W-1:0] trunc_int(input logic signed [RAW_W-1:0] v);
    logic signed [RAW_W-1:0] adj;
    adj = v + (v[RAW_W-1] ? 32'sd65535 : 32'sd0);
    return adj[RAW_W-1:RAW_W-COORD_W];
  endfunction

  // Saturate a 17-bit difference to the 16-bit signed range.
  function automatic logic signed [COORD_W-1:0] sat16(input logic signed [COORD_W:0] v);
    logic [COORD_W-1:0] res;
    if (v[COORD_W] != v[COORD_W-1]) begin
      res = v[COORD_W] ? {1'b1, {(COORD_W-1){1'b0}}} : {1'b0, {(COORD_W-1){1'b1}}};
    end else begin
      res = v[COORD_W-1:0];
    end
    return res;
  endfunction

endpackage

/* src/drd_record_tracker.sv */
`include "detection_record_decoder_assert.svh"

module drd_record_tracker #(
  parameter int MAX_CLASSES = drd_pkg::DEF_MAX_CLASSES
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   en,
  input  logic                                   in_valid,
  input  logic signed [drd_pkg::RAW_W-1:0]       raw_value,
  input  logic signed [drd_pkg::RAW_W-1:0]       score_threshold,
  input  logic [drd_pkg::CLASS_COUNT_W-1:0]      class_count,
  output logic                                   rec_valid,
  output drd_pkg::rec_t                          rec
);
  import drd_pkg::*;

  localparam int POS_W = $clog2(MAX_CLASSES + BOX_VALUES);
  localparam int CLS_W = (MAX_CLASSES > 1) ? $clog2(MAX_CLASSES) : 1;
  localparam int CMP_W = (POS_W > CLASS_COUNT_W) ? POS_W : CLASS_COUNT_W;
  localparam logic [POS_W-1:0] POS_MAX = POS_W'(MAX_CLASSES + BOX_VALUES - 1);

  logic [POS_W-1:0]        pos_r, pos_nxt;
  logic signed [RAW_W-1:0] cx_r, cx_nxt;
  logic signed [RAW_W-1:0] cy_r, cy_nxt;
  logic signed [RAW_W-1:0] sx_r, sx_nxt;
  logic signed [RAW_W-1:0] sy_r, sy_nxt;
  logic signed [RAW_W-1:0] obj_r, obj_nxt;
  logic signed [RAW_W-1:0] best_r, best_nxt;
  logic [CLS_W-1:0]        best_cls_r, best_cls_nxt;
  logic                    rec_valid_r, rec_valid_nxt;
  rec_t                    rec_r, rec_nxt;

  logic [CMP_W-1:0] cc_ext;
  logic [CMP_W-1:0] classes;
  logic [POS_W-1:0] last_pos;
  logic [CLS_W-1:0] cls_idx;
  logic             in_fire;
  logic             is_box;
  logic             at_last;
  logic             take;
  logic             pass;

  // Effective class count, clamped to one and to the class limit.
  always_comb begin
    cc_ext = CMP_W'(class_count);
    if (cc_ext == '0) begin
      classes = CMP_W'(1);
    end else if (cc_ext > CMP_W'(MAX_CLASSES)) begin
      classes = CMP_W'(MAX_CLASSES);
    end else begin
      classes = cc_ext;
    end
    last_pos = POS_W'(classes + CMP_W'(BOX_VALUES - 1));
  end

  // Position decode and the running maximum compare.
  always_comb begin
    in_fire  = in_valid && en;
    is_box   = pos_r < POS_W'(BOX_VALUES);
    at_last  = pos_r >= last_pos;
    cls_idx  = CLS_W'(pos_r - POS_W'(BOX_VALUES));
    take     = (pos_r == POS_W'(BOX_VALUES)) || (raw_value > best_r);
    best_nxt     = take ? raw_value : best_r;
    best_cls_nxt = take ? cls_idx : best_cls_r;
    pass     = (obj_r >= score_threshold) && (best_nxt >= score_threshold);
  end

  // Record state update on each input transfer.
  always_comb begin
    pos_nxt = pos_r;
    cx_nxt  = cx_r;
    cy_nxt  = cy_r;
    sx_nxt  = sx_r;
    sy_nxt  = sy_r;
    obj_nxt = obj_r;
    if (in_fire) begin
      if (is_box) begin
        case (pos_r)
          POS_W'(POS_CENTER_X): cx_nxt = raw_value;
          POS_W'(POS_CENTER_Y): cy_nxt = raw_value;
          POS_W'(POS_SIZE_X):   sx_nxt = raw_value;
          POS_W'(POS_SIZE_Y):   sy_nxt = raw_value;
          default:              obj_nxt = raw_value;
        endcase
        pos_nxt = pos_r + POS_W'(1);
      end else if (at_last) begin
        pos_nxt = '0;
      end else begin
        pos_nxt = pos_r + POS_W'(1);
      end
    end
  end

  // Finished record handed to the box stage.
  always_comb begin
    rec_valid_nxt       = in_fire && !is_box && at_last && pass;
    rec_nxt.center_x    = cx_r;
    rec_nxt.center_y    = cy_r;
    rec_nxt.size_x      = sx_r;
    rec_nxt.size_y      = sy_r;
    rec_nxt.objectness  = obj_r;
    rec_nxt.best_score  = best_nxt;
    rec_nxt.best_class  = CLASS_INDEX_W'(best_cls_nxt);
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r       <= '0;
      rec_valid_r <= 1'b0;
    end else begin
      pos_r <= pos_nxt;
      if (en) begin
        rec_valid_r <= rec_valid_nxt;
      end
    end
  end

  // Box values and running maximum.
  always_ff @(posedge clk) begin
    cx_r  <= cx_nxt;
    cy_r  <= cy_nxt;
    sx_r  <= sx_nxt;
    sy_r  <= sy_nxt;
    obj_r <= obj_nxt;
    if (in_fire && !is_box) begin
      best_r     <= best_nxt;
      best_cls_r <= best_cls_nxt;
    end
    if (en) begin
      rec_r <= rec_nxt;
    end
  end

  assign rec_valid = rec_valid_r;
  assign rec       = rec_r;

  // The position never runs past the last score of the largest record.
  `DRD_ASSERT_IMPL(a_pos_bound, clk, rst_n, 1'b1, pos_r <= POS_MAX, "record position out of range")
  // A waiting record always leaves the tracker at the head of a new record.
  `DRD_ASSERT_IMPL(a_rec_restart, clk, rst_n, rec_valid_r, pos_r == '0, "record not restarted")

endmodule

/* src/drd_box_calc.sv */
`include "detection_record_decoder_assert.svh"

module drd_box_calc (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   en,
  input  logic                                   rec_valid,
  input  drd_pkg::rec_t                          rec,
  output logic                                   out_valid,
  output logic signed [drd_pkg::COORD_W-1:0]     box_left,
  output logic signed [drd_pkg::COORD_W-1:0]     box_top,
  output logic signed [drd_pkg::COORD_W-1:0]     box_width,
  output logic signed [drd_pkg::COORD_W-1:0]     box_height,
  output logic [drd_pkg::CLASS_INDEX_W-1:0]      class_index,
  output logic signed [drd_pkg::SCORE_W-1:0]     detection_score
);
  import drd_pkg::*;

  localparam int SAT_HI = PROD_W - 1;
  localparam int SAT_LO = SCORE_W + 15;

  // Truncation and product stage.
  logic                      b_valid_r;
  logic signed [COORD_W-1:0] b_cx_r, b_cx_nxt;
  logic signed [COORD_W-1:0] b_cy_r, b_cy_nxt;
  logic signed [COORD_W-1:0] b_w_r, b_w_nxt;
  logic signed [COORD_W-1:0] b_h_r, b_h_nxt;
  logic [CLASS_INDEX_W-1:0]  b_cls_r;
  logic signed [PROD_W-1:0]  b_prod_r, b_prod_nxt;
  logic signed [RAW_W-1:0]   score_s;
  logic signed [RAW_W-1:0]   obj_s;

  // Output register.
  logic                      out_valid_r;
  logic signed [COORD_W-1:0] left_r, left_nxt;
  logic signed [COORD_W-1:0] top_r, top_nxt;
  logic signed [COORD_W-1:0] width_r;
  logic signed [COORD_W-1:0] height_r;
  logic [CLASS_INDEX_W-1:0]  cls_r;
  logic signed [SCORE_W-1:0] score_r, score_nxt;
  logic signed [COORD_W-1:0] half_w;
  logic signed [COORD_W-1:0] half_h;
  logic                      score_ovf;

  // Integer parts of the box values and the score product.
  always_comb begin
    b_cx_nxt   = trunc_int($signed(rec.center_x));
    b_cy_nxt   = trunc_int($signed(rec.center_y));
    b_w_nxt    = trunc_int($signed(rec.size_x));
    b_h_nxt    = trunc_int($signed(rec.size_y));
    score_s    = $signed(rec.best_score);
    obj_s      = $signed(rec.objectness);
    b_prod_nxt = PROD_W'(score_s) * PROD_W'(obj_s);
  end

  // Edges from center and half size, and the saturated Q16.16 score.
  always_comb begin
    half_w    = (b_w_r + $signed({{(COORD_W-1){1'b0}}, b_w_r[COORD_W-1]})) >>> 1;
    half_h    = (b_h_r + $signed({{(COORD_W-1){1'b0}}, b_h_r[COORD_W-1]})) >>> 1;
    left_nxt  = sat16((COORD_W+1)'(b_cx_r) - (COORD_W+1)'(half_w));
    top_nxt   = sat16((COORD_W+1)'(b_cy_r) - (COORD_W+1)'(half_h));
    score_ovf = !((&b_prod_r[SAT_HI:SAT_LO]) || !(|b_prod_r[SAT_HI:SAT_LO]));
    if (score_ovf) begin
      score_nxt = b_prod_r[SAT_HI] ? {1'b1, {(SCORE_W-1){1'b0}}}
                                   : {1'b0, {(SCORE_W-1){1'b1}}};
    end else begin
      score_nxt = b_prod_r[SAT_LO:16];
    end
  end

  // Valid flags move only when the pipeline advances.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_valid_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      b_valid_r   <= rec_valid;
      out_valid_r <= b_valid_r;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (en) begin
      b_cx_r   <= b_cx_nxt;
      b_cy_r   <= b_cy_nxt;
      b_w_r    <= b_w_nxt;
      b_h_r    <= b_h_nxt;
      b_cls_r  <= rec.best_class;
      b_prod_r <= b_prod_nxt;
      left_r   <= left_nxt;
      top_r    <= top_nxt;
      width_r  <= b_w_r;
      height_r <= b_h_r;
      cls_r    <= b_cls_r;
      score_r  <= score_nxt;
    end
  end

  assign out_valid       = out_valid_r;
  assign box_left        = left_r;
  assign box_top         = top_r;
  assign box_width       = width_r;
  assign box_height      = height_r;
  assign class_index     = cls_r;
  assign detection_score = score_r;

  // A result only appears after the product stage held a record.
  `DRD_ASSERT_IMPL(a_out_from_prod, clk, rst_n, $rose(out_valid_r), $past(b_valid_r), "result without record")
  // A stalled pipeline keeps its record in the product stage.
  `DRD_ASSERT_NEXT(a_prod_hold, clk, rst_n, b_valid_r && !en, b_valid_r, "record dropped in stall")

endmodule

/* src/detection_record_decoder.sv */
// The last score passes the tracker, product and output registers to out_tvalid.
// One raw value per cycle unless the output stalls; detections add no stall.
// The pipeline advances whenever the output register is empty or being taken.
// Reset (rst_n low, synchronous) clears the record position and all valid flags and
// restores score_threshold to 0.5 and class_count to 80.
module detection_record_decoder #(
  parameter int MAX_CLASSES = drd_pkg::DEF_MAX_CLASSES
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  input  logic [drd_pkg::IN_DATA_W-1:0]        in_tdata,   // [31:0] raw_value
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  // [15:0] box_left, [31:16] box_top, [47:32] box_width, [63:48] box_height,
  // [70:64] class_index, [102:71] detection_score, [103] zero
  output logic [drd_pkg::OUT_DATA_W-1:0]       out_tdata,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [drd_pkg::CFG_INDEX_W-1:0]      cfg_index,
  input  logic [drd_pkg::CFG_DATA_W-1:0]       cfg_data
);
  import drd_pkg::*;

  logic signed [RAW_W-1:0]    thr_r, thr_nxt;
  logic [CLASS_COUNT_W-1:0]   cc_r, cc_nxt;
  logic                       cfg_fire;
  logic                       en;
  logic                       rec_valid;
  rec_t                       rec;
  logic                       out_valid;
  logic signed [COORD_W-1:0]  box_left;
  logic signed [COORD_W-1:0]  box_top;
  logic signed [COORD_W-1:0]  box_width;
  logic signed [COORD_W-1:0]  box_height;
  logic [CLASS_INDEX_W-1:0]   class_index;
  logic signed [SCORE_W-1:0]  detection_score;

  // Configuration writes are always accepted.
  assign cfg_ready = 1'b1;
  assign cfg_fire  = cfg_valid && cfg_ready;

  always_comb begin
    thr_nxt = thr_r;
    cc_nxt  = cc_r;
    if (cfg_fire) begin
      case (cfg_index)
        REG_SCORE_THRESHOLD: thr_nxt = $signed(cfg_data[RAW_W-1:0]);
        REG_CLASS_COUNT:     cc_nxt  = cfg_data[CLASS_COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= THRESHOLD_RESET;
      cc_r  <= CLASS_COUNT_RESET;
    end else begin
      thr_r <= thr_nxt;
      cc_r  <= cc_nxt;
    end
  end

  // The whole pipeline advances together unless a result is stuck at the output.
  assign en        = !out_valid || out_tready;
  assign in_tready = en;

  drd_record_tracker #(
    .MAX_CLASSES(MAX_CLASSES)
  ) u_tracker (
    .clk             (clk),
    .rst_n           (rst_n),
    .en              (en),
    .in_valid        (in_tvalid),
    .raw_value       ($signed(in_tdata[RAW_W-1:0])),
    .score_threshold (thr_r),
    .class_count     (cc_r),
    .rec_valid       (rec_valid),
    .rec             (rec)
  );

  drd_box_calc u_box (
    .clk             (clk),
    .rst_n           (rst_n),
    .en              (en),
    .rec_valid       (rec_valid),
    .rec             (rec),
    .out_valid       (out_valid),
    .box_left        (box_left),
    .box_top         (box_top),
    .box_width       (box_width),
    .box_height      (box_height),
    .class_index     (class_index),
    .detection_score (detection_score)
  );

  // Result packing, first field in the lowest bits.
  assign out_tvalid = out_valid;
  assign out_tdata  = {1'b0, detection_score, class_index,
                       box_height, box_width, box_top, box_left};

endmodule
